@@ design/spo_pkg.sv @@
// Shared types and constants for the strided permute offset unit.
`timescale 1ns / 1ps

package spo_pkg;

  // View rank handled by the register map
  localparam int NUM_DIMS    = 4;
  localparam int SHAPE_W     = 16;
  localparam int STRIDE_W    = 32;
  localparam int INDEX_W     = 32;
  localparam int OFFSET_W    = 40;
  localparam int DIGIT_W     = 32;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;
  // Remainder digits collected along the divider chain, one per inner dimension
  localparam int DIGITS_W    = (NUM_DIMS - 1) * SHAPE_W;
  localparam int PROD_W      = DIGIT_W + STRIDE_W;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_SHAPE_DIM1  = 3'd0,
    CFG_SHAPE_DIM2  = 3'd1,
    CFG_SHAPE_DIM3  = 3'd2,
    CFG_STRIDE_DIM0 = 3'd3,
    CFG_STRIDE_DIM1 = 3'd4,
    CFG_STRIDE_DIM2 = 3'd5,
    CFG_STRIDE_DIM3 = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [INDEX_W-1:0] linear_index;
    logic               last_in;
  } spo_in_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] source_offset;
    logic                offset_overflow;
    logic                last_out;
  } spo_out_t;

endpackage

@@ design/spo_div_cell.sv @@
// One restoring division step: shifts in a dividend bit, emits one quotient bit.
`timescale 1ns / 1ps

module spo_div_cell #(
  parameter int DW = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic [spo_pkg::SHAPE_W-1:0]  divisor,
  input  logic                         in_valid,
  input  logic                         in_last,
  input  logic [spo_pkg::SHAPE_W-1:0]  in_rem,
  input  logic [DW-1:0]                in_word,
  input  logic [spo_pkg::DIGITS_W-1:0] in_digits,
  output logic                         out_valid,
  output logic                         out_last,
  output logic [spo_pkg::SHAPE_W-1:0]  out_rem,
  output logic [DW-1:0]                out_word,
  output logic [spo_pkg::DIGITS_W-1:0] out_digits
);
  import spo_pkg::*;

  logic                valid;
  logic                last;
  logic [SHAPE_W-1:0]  rem;
  logic [DW-1:0]       word;
  logic [DIGITS_W-1:0] digits;

  logic [SHAPE_W:0]    partial;
  logic [SHAPE_W+1:0]  diff;
  logic                qbit;
  logic [SHAPE_W-1:0]  rem_next;
  logic [DW-1:0]       word_next;

  // Trial subtract of the divisor from the shifted partial remainder
  always_comb begin
    partial   = {in_rem, in_word[DW-1]};
    diff      = {1'b0, partial} - {2'b00, divisor};
    qbit      = ~diff[SHAPE_W+1];
    rem_next  = qbit ? diff[SHAPE_W-1:0] : partial[SHAPE_W-1:0];
    word_next = {in_word[DW-2:0], qbit};
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (en) begin
      last   <= in_last;
      rem    <= rem_next;
      word   <= word_next;
      digits <= in_digits;
    end
  end

  assign out_valid  = valid;
  assign out_last   = last;
  assign out_rem    = rem;
  assign out_word   = word;
  assign out_digits = digits;

  // Partial remainder always stays below the divisor
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    valid |-> rem < divisor)
    else $error("division cell remainder not below divisor");

endmodule

@@ design/spo_mac.sv @@
// Digit times stride products and their 40-bit wrapped sum with overflow flag.
`timescale 1ns / 1ps

module spo_mac (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic                         in_last,
  input  logic [spo_pkg::DIGIT_W-1:0]  digit  [spo_pkg::NUM_DIMS],
  input  logic [spo_pkg::STRIDE_W-1:0] stride [spo_pkg::NUM_DIMS],
  output logic                         out_valid,
  output spo_pkg::spo_out_t            out_data
);
  import spo_pkg::*;

  localparam int SUM2_W = PROD_W + 1;
  localparam int SUM4_W = PROD_W + 2;

  logic              p_valid;
  logic              p_last;
  logic [PROD_W-1:0] prod [NUM_DIMS];

  logic              s_valid;
  logic              s_last;
  logic [SUM2_W-1:0] sum_lo;
  logic [SUM2_W-1:0] sum_hi;

  logic              o_valid;
  spo_out_t          o_data;
  logic [SUM4_W-1:0] total;

  // Control for the three stages
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
      s_valid <= 1'b0;
      o_valid <= 1'b0;
    end else if (en) begin
      p_valid <= in_valid;
      s_valid <= p_valid;
      o_valid <= s_valid;
    end
  end

  // Stage 1: one 32x32 product per dimension
  always_ff @(posedge clk) begin
    if (en) begin
      p_last <= in_last;
      for (int d = 0; d < NUM_DIMS; d++) begin
        prod[d] <= PROD_W'(digit[d]) * PROD_W'(stride[d]);
      end
    end
  end

  // Stage 2: pairwise sums
  always_ff @(posedge clk) begin
    if (en) begin
      s_last <= p_last;
      sum_lo <= {1'b0, prod[0]} + {1'b0, prod[1]};
      sum_hi <= {1'b0, prod[2]} + {1'b0, prod[3]};
    end
  end

  // Stage 3: full sum, wrap at the offset width, flag any higher bits
  assign total = {1'b0, sum_lo} + {1'b0, sum_hi};

  always_ff @(posedge clk) begin
    if (en) begin
      o_data.source_offset   <= total[OFFSET_W-1:0];
      o_data.offset_overflow <= |total[SUM4_W-1:OFFSET_W];
      o_data.last_out        <= s_last;
    end
  end

  assign out_valid = o_valid;
  assign out_data  = o_data;

  // Output valid follows the sum stage in the next cycle whenever the pipe moves
  a_valid_advance: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $past(en) |-> o_valid == $past(s_valid))
    else $error("output valid did not follow sum stage");

endmodule

@@ design/strided_permute_offset_unit.sv @@
// Top level: config registers, mixed-radix divider cell chain and offset MAC.
`timescale 1ns / 1ps

// Usage:
//   Index channel (idx_valid / idx_stall / idx_data) carries one linear index
//   and a last marker per transfer; offset channel (ofs_valid / ofs_stall /
//   ofs_data) returns exactly one source offset, overflow flag and last marker
//   per index, in order.
//   Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data) writes the
//   shape and stride registers; write only while no index is in flight.
//   Unknown register indexes are dropped.
//   The index is split into digits by a chain of restoring division cells,
//   one quotient bit per cell per cycle while the pipeline moves, innermost
//   dimension first; three MAC stages then multiply by the strides and sum.
//   Throughput: one index per cycle while no result is stalled at the output.
//   Receiver stall: the whole pipeline holds while a result waits on the
//   output register, and idx_stall is raised for that time.
//   Reset: clears all pipeline valid bits and returns shapes to 1, strides
//   to 0 except the innermost stride, which becomes 1.
module strided_permute_offset_unit #(
  parameter int MAX_DIMS    = 4,
  parameter int INDEX_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           idx_valid,
  output logic                           idx_stall,
  input  spo_pkg::spo_in_t               idx_data,
  output logic                           ofs_valid,
  input  logic                           ofs_stall,
  output spo_pkg::spo_out_t              ofs_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [spo_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [spo_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import spo_pkg::*;

  localparam int DW      = (INDEX_WIDTH < INDEX_W) ? INDEX_WIDTH : INDEX_W;
  localparam int NUM_DIV = MAX_DIMS - 1;
  localparam int NC      = NUM_DIV * DW;
  localparam int FIRST   = NUM_DIMS - MAX_DIMS;

  logic [SHAPE_W-1:0]  shape_dim1;
  logic [SHAPE_W-1:0]  shape_dim2;
  logic [SHAPE_W-1:0]  shape_dim3;
  logic [STRIDE_W-1:0] stride [NUM_DIMS];
  logic [SHAPE_W-1:0]  divisor [NUM_DIMS-1];

  logic en;

  logic                chain_valid  [0:NC];
  logic                chain_last   [0:NC];
  logic [SHAPE_W-1:0]  chain_rem    [0:NC];
  logic [DW-1:0]       chain_word   [0:NC];
  logic [DIGITS_W-1:0] chain_digits [0:NC];

  logic [DIGIT_W-1:0]  digit [NUM_DIMS];

  // Pipeline moves unless a result sits stalled in the output register
  assign en        = ~(ofs_valid & ofs_stall);
  assign idx_stall = rst | ~en;
  assign cfg_ready = ~rst;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      shape_dim1 <= SHAPE_W'(1);
      shape_dim2 <= SHAPE_W'(1);
      shape_dim3 <= SHAPE_W'(1);
      stride[0]  <= '0;
      stride[1]  <= '0;
      stride[2]  <= '0;
      stride[3]  <= STRIDE_W'(1);
    end else if (cfg_valid) begin
      unique case (cfg_reg_e'(cfg_index))
        CFG_SHAPE_DIM1:  shape_dim1 <= cfg_data[SHAPE_W-1:0];
        CFG_SHAPE_DIM2:  shape_dim2 <= cfg_data[SHAPE_W-1:0];
        CFG_SHAPE_DIM3:  shape_dim3 <= cfg_data[SHAPE_W-1:0];
        CFG_STRIDE_DIM0: stride[0]  <= cfg_data[STRIDE_W-1:0];
        CFG_STRIDE_DIM1: stride[1]  <= cfg_data[STRIDE_W-1:0];
        CFG_STRIDE_DIM2: stride[2]  <= cfg_data[STRIDE_W-1:0];
        CFG_STRIDE_DIM3: stride[3]  <= cfg_data[STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  // Divisors innermost first; a zero shape divides as one
  assign divisor[0] = (shape_dim3 == '0) ? SHAPE_W'(1) : shape_dim3;
  assign divisor[1] = (shape_dim2 == '0) ? SHAPE_W'(1) : shape_dim2;
  assign divisor[2] = (shape_dim1 == '0) ? SHAPE_W'(1) : shape_dim1;

  // Chain head
  assign chain_valid[0]  = idx_valid;
  assign chain_last[0]   = idx_data.last_in;
  assign chain_rem[0]    = '0;
  assign chain_word[0]   = idx_data.linear_index[DW-1:0];
  assign chain_digits[0] = '0;

  // Division cell chain; at each division boundary the remainder is parked
  // as a digit and the quotient becomes the next dividend
  for (genvar c = 0; c < NC; c++) begin : g_cell
    localparam int K = c / DW;
    logic [SHAPE_W-1:0]  cin_rem;
    logic [DIGITS_W-1:0] cin_digits;

    if (c > 0 && (c % DW) == 0) begin : g_bound
      always_comb begin
        cin_digits = chain_digits[c];
        cin_digits[(K-1)*SHAPE_W +: SHAPE_W] = chain_rem[c];
      end
      assign cin_rem = '0;
    end else begin : g_pass
      assign cin_digits = chain_digits[c];
      assign cin_rem    = chain_rem[c];
    end

    spo_div_cell #(
      .DW (DW)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .en         (en),
      .divisor    (divisor[K]),
      .in_valid   (chain_valid[c]),
      .in_last    (chain_last[c]),
      .in_rem     (cin_rem),
      .in_word    (chain_word[c]),
      .in_digits  (cin_digits),
      .out_valid  (chain_valid[c+1]),
      .out_last   (chain_last[c+1]),
      .out_rem    (chain_rem[c+1]),
      .out_word   (chain_word[c+1]),
      .out_digits (chain_digits[c+1])
    );
  end

  // Map chain results onto dimensions: remainders for the inner ones,
  // the final quotient for the leading used dimension, zero for the rest
  always_comb begin
    for (int d = 0; d < NUM_DIMS; d++) begin
      digit[d] = '0;
    end
    for (int k = 0; k < NUM_DIMS - 1; k++) begin
      if (k < NUM_DIV - 1) begin
        digit[2'(NUM_DIMS-1-k)] = DIGIT_W'(chain_digits[NC][k*SHAPE_W +: SHAPE_W]);
      end else if (k == NUM_DIV - 1) begin
        digit[2'(NUM_DIMS-1-k)] = DIGIT_W'(chain_rem[NC]);
      end
    end
    digit[2'(FIRST)] = DIGIT_W'(chain_word[NC]);
  end

  spo_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (chain_valid[NC]),
    .in_last   (chain_last[NC]),
    .digit     (digit),
    .stride    (stride),
    .out_valid (ofs_valid),
    .out_data  (ofs_data)
  );

  // A held result blocks new index transfers
  a_hold_blocks_input: assert property (@(posedge clk) disable iff (rst)
    ofs_valid && ofs_stall |-> idx_stall)
    else $error("index accepted while result stalled");

  // All strides zero gives a zero offset and no overflow
  a_zero_strides: assert property (@(posedge clk) disable iff (rst)
    ofs_valid && stride[0] == '0 && stride[1] == '0 && stride[2] == '0 &&
    stride[3] == '0 |-> ofs_data.source_offset == '0 && !ofs_data.offset_overflow)
    else $error("nonzero offset with all strides zero");

endmodule

@@ sim/strided_permute_offset_checker.sv @@
// Checker for the strided permute offset unit: predicts each offset and compares results.
`timescale 1ns / 1ps

module strided_permute_offset_checker #(
  parameter int MAX_DIMS    = 4,
  parameter int INDEX_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            idx_valid,
  input  logic                            idx_stall,
  input  spo_pkg::spo_in_t                idx_data,
  input  logic                            ofs_valid,
  input  logic                            ofs_stall,
  input  spo_pkg::spo_out_t               ofs_data,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [spo_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [spo_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                              mismatches,
  output int                              outstanding
);
  import spo_pkg::*;

  // Shadow copy of the view registers; shape entry 0 is never used
  logic [SHAPE_W-1:0]  view_shape  [NUM_DIMS];
  logic [STRIDE_W-1:0] view_stride [NUM_DIMS];

  // Offsets predicted for indexes already taken, oldest first
  spo_out_t expected_offsets [$];

  // Split the index into mixed-radix digits and sum digit times stride
  function automatic spo_out_t predict_offset(spo_in_t item);
    logic [47:0] radix [NUM_DIMS];
    logic [47:0] rem;
    logic [47:0] digit;
    logic [79:0] prod;
    logic [40:0] total;
    logic        ovf;
    int          d;
    int          lead;
    spo_out_t    res;
    radix[NUM_DIMS-1] = 48'd1;
    for (d = NUM_DIMS - 2; d >= 0; d--) begin
      // a zero shape behaves as a shape of one
      radix[d] = radix[d+1] * ((view_shape[d+1] == '0) ? 48'd1 : 48'(view_shape[d+1]));
    end
    rem = 48'(item.linear_index) & ((48'd1 << INDEX_WIDTH) - 48'd1);
    // with fewer dims only the innermost ones count, the first of them unbounded
    lead = NUM_DIMS - MAX_DIMS;
    if (lead < 0) lead = 0;
    if (lead > NUM_DIMS - 1) lead = NUM_DIMS - 1;
    total = '0;
    ovf   = 1'b0;
    for (d = lead; d < NUM_DIMS; d++) begin
      digit = rem / radix[d];
      rem   = rem % radix[d];
      prod  = 80'(digit) * 80'(view_stride[d]);
      if (prod[79:OFFSET_W] != '0) ovf = 1'b1;
      total = total + {1'b0, prod[OFFSET_W-1:0]};
      if (total[OFFSET_W]) begin
        ovf             = 1'b1;
        total[OFFSET_W] = 1'b0;
      end
    end
    res.source_offset   = total[OFFSET_W-1:0];
    res.offset_overflow = ovf;
    res.last_out        = item.last_in;
    return res;
  endfunction

  // Watch all three channels; results are checked before new indexes are queued
  always @(posedge clk) begin
    spo_out_t want;
    int       errs;
    errs = 0;
    if (rst) begin
      for (int d = 0; d < NUM_DIMS; d++) begin
        view_shape[d]  = SHAPE_W'(1);
        view_stride[d] = '0;
      end
      view_stride[NUM_DIMS-1] = STRIDE_W'(1);
      expected_offsets.delete();
      mismatches  <= 0;
      outstanding <= 0;
    end else begin
      if (ofs_valid && !ofs_stall) begin
        if (expected_offsets.size() == 0) begin
          $display("%0t: offset transfer with none expected, got %h", $time, ofs_data);
          errs++;
        end else begin
          want = expected_offsets.pop_front();
          if (ofs_data.source_offset !== want.source_offset) begin
            $display("%0t: source_offset expected %h, got %h", $time,
                     want.source_offset, ofs_data.source_offset);
            errs++;
          end
          if (ofs_data.offset_overflow !== want.offset_overflow) begin
            $display("%0t: offset_overflow expected %b, got %b", $time,
                     want.offset_overflow, ofs_data.offset_overflow);
            errs++;
          end
          if (ofs_data.last_out !== want.last_out) begin
            $display("%0t: last_out expected %b, got %b", $time,
                     want.last_out, ofs_data.last_out);
            errs++;
          end
        end
      end
      if (idx_valid && !idx_stall) expected_offsets.push_back(predict_offset(idx_data));
      // register writes; unknown indexes are dropped
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_e'(cfg_index))
          CFG_SHAPE_DIM1:  view_shape[1]  = cfg_data[SHAPE_W-1:0];
          CFG_SHAPE_DIM2:  view_shape[2]  = cfg_data[SHAPE_W-1:0];
          CFG_SHAPE_DIM3:  view_shape[3]  = cfg_data[SHAPE_W-1:0];
          CFG_STRIDE_DIM0: view_stride[0] = cfg_data[STRIDE_W-1:0];
          CFG_STRIDE_DIM1: view_stride[1] = cfg_data[STRIDE_W-1:0];
          CFG_STRIDE_DIM2: view_stride[2] = cfg_data[STRIDE_W-1:0];
          CFG_STRIDE_DIM3: view_stride[3] = cfg_data[STRIDE_W-1:0];
          default: ;
        endcase
      end
      mismatches  <= mismatches + errs;
      outstanding <= expected_offsets.size();
    end
  end

endmodule

@@ sim/tb_strided_permute_offset_unit.sv @@
// Testbench top for the strided permute offset unit: stimulus, stalls, watchdog and verdict.
`timescale 1ns / 1ps

module tb_strided_permute_offset_unit;
  import spo_pkg::*;

  localparam int MAX_DIMS     = 4;
  localparam int INDEX_WIDTH  = 32;
  localparam int PIPE_LATENCY = (MAX_DIMS - 1) * ((INDEX_WIDTH < 32) ? INDEX_WIDTH : 32) + 3;
  localparam int HOLD_CYCLES  = 400;
  localparam int IDLE_LIMIT   = 4000;
  localparam int NUM_PHASES   = 8;
  localparam int NUM_REGS     = 7;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 3'd7;

  logic                   clk;
  logic                   rst       = 1'b1;
  logic                   idx_valid = 1'b0;
  logic                   idx_stall;
  spo_in_t                idx_data  = '0;
  logic                   ofs_valid;
  logic                   ofs_stall = 1'b0;
  spo_out_t               ofs_data;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  int check_errors;
  int pending_results;
  int idle_cycles = 0;
  bit hold_req    = 1'b0;

  // Shapes as the block sees them (zero read as one), used to aim indexes
  logic [15:0] stim_shape [NUM_DIMS];

  strided_permute_offset_unit #(
    .MAX_DIMS    (MAX_DIMS),
    .INDEX_WIDTH (INDEX_WIDTH)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .idx_valid (idx_valid),
    .idx_stall (idx_stall),
    .idx_data  (idx_data),
    .ofs_valid (ofs_valid),
    .ofs_stall (ofs_stall),
    .ofs_data  (ofs_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  strided_permute_offset_checker #(
    .MAX_DIMS    (MAX_DIMS),
    .INDEX_WIDTH (INDEX_WIDTH)
  ) u_checker (
    .clk         (clk),
    .rst         (rst),
    .idx_valid   (idx_valid),
    .idx_stall   (idx_stall),
    .idx_data    (idx_data),
    .ofs_valid   (ofs_valid),
    .ofs_stall   (ofs_stall),
    .ofs_data    (ofs_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (check_errors),
    .outstanding (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: ends the run after too long without any transfer
  always @(posedge clk) begin
    if (rst || (idx_valid && !idx_stall) || (ofs_valid && !ofs_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver: stall pattern changes every run; one long hold on request
  initial begin : receiver
    int mode;
    int run;
    int hold_left;
    int tick;
    hold_left = 0;
    tick      = 0;
    forever begin
      mode = $urandom_range(0, 3);
      run  = $urandom_range(20, 200);
      repeat (run) begin
        @(posedge clk);
        tick++;
        if (hold_req) begin
          hold_req  = 1'b0;
          hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
          hold_left--;
          ofs_stall <= 1'b1;
        end else begin
          case (mode)
            0: ofs_stall <= 1'b0;
            1: ofs_stall <= ($urandom_range(0, 3) == 0);
            2: ofs_stall <= 1'($urandom_range(0, 1));
            default: ofs_stall <= ((tick % 7) < 3);
          endcase
        end
      end
    end
  end

  // One index transfer; valid stays high for the caller to reuse or drop
  task automatic send_index(input spo_in_t item);
    idx_valid <= 1'b1;
    idx_data  <= item;
    do @(posedge clk); while (!(idx_valid && !idx_stall));
  endtask

  // One register write; valid stays high until the caller drops it
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input logic [31:0] value);
    logic [15:0] shape;
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    shape = (value[15:0] == '0) ? 16'd1 : value[15:0];
    case (cfg_reg_e'(index))
      CFG_SHAPE_DIM1: stim_shape[1] = shape;
      CFG_SHAPE_DIM2: stim_shape[2] = shape;
      CFG_SHAPE_DIM3: stim_shape[3] = shape;
      default: ;
    endcase
  endtask

  // Write every register in index order, optionally poke the unused index too
  task automatic program_regs(input logic [31:0] words [NUM_REGS], input bit poke_unused);
    for (int i = 0; i < NUM_REGS; i++) write_reg(cfg_reg_e'(i), words[i]);
    if (poke_unused) write_reg(CFG_UNUSED_INDEX, $urandom);
    cfg_valid <= 1'b0;
  endtask

  // Block until every predicted offset has come back
  task automatic wait_drained();
    do @(posedge clk); while (pending_results != 0);
  endtask

  function automatic logic [31:0] random_shape_word();
    case ($urandom_range(0, 9))
      0: return {16'($urandom), 16'd0};
      1: return 32'h0000_FFFF;
      2: return 32'd1;
      3, 4, 5, 6: return $urandom_range(2, 16);
      default: return {16'($urandom), 16'($urandom_range(1, 65535))};
    endcase
  endfunction

  function automatic logic [31:0] random_stride_word();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2, 3, 4, 5: return $urandom_range(0, 64);
      default: return $urandom;
    endcase
  endfunction

  // Half the indexes inside up to eight spans of the view, some near digit boundaries
  function automatic spo_in_t make_item();
    logic [63:0] span;
    logic [63:0] radix;
    logic [31:0] value;
    spo_in_t     item;
    span = 64'(stim_shape[1]) * 64'(stim_shape[2]) * 64'(stim_shape[3]);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: value = 32'(64'($urandom) % (span * $urandom_range(1, 8)));
      5, 6, 7: value = $urandom;
      8: begin
        case ($urandom_range(0, 2))
          0: radix = 64'(stim_shape[3]);
          1: radix = 64'(stim_shape[2]) * 64'(stim_shape[3]);
          default: radix = span;
        endcase
        value = 32'(radix * $urandom_range(0, 8) - $urandom_range(0, 1));
      end
      default: value = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
    endcase
    item.linear_index = value;
    item.last_in      = ($urandom_range(0, 7) == 0);
    return item;
  endfunction

  // Random indexes in bursts, with gaps between bursts when asked
  task automatic send_phase(input int count, input bit gaps);
    int burst_left;
    int k;
    burst_left = 0;
    for (k = 0; k < count; k++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 32);
        if (gaps && k != 0 && $urandom_range(0, 3) != 0) begin
          idx_valid <= 1'b0;
          repeat ($urandom_range(1, 6)) @(posedge clk);
        end
      end
      send_index(make_item());
      burst_left--;
    end
    idx_valid <= 1'b0;
  endtask

  // Main stimulus
  initial begin
    logic [31:0] cfg_words [NUM_REGS];
    logic [31:0] small_view [10];
    int          count;
    for (int d = 0; d < NUM_DIMS; d++) stim_shape[d] = 16'd1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset registers: extremes of the index and both last values
    send_index(spo_in_t'{32'h0, 1'b0});
    send_index(spo_in_t'{32'hFFFF_FFFF, 1'b1});
    send_index(spo_in_t'{32'h1, 1'b0});
    idx_valid <= 1'b0;
    wait_drained();

    // small 3x4x5 inner view, high shape bits must be dropped
    cfg_words = '{32'h0001_0003, 32'd4, 32'd5, 32'd1, 32'd7, 32'd100, 32'd3000};
    program_regs(cfg_words, 1'b0);
    small_view = '{32'd0, 32'd4, 32'd5, 32'd19, 32'd20, 32'd59, 32'd60, 32'd61,
                   32'd1000, 32'hFFFF_FFFF};
    for (int i = 0; i < 10; i++) send_index(spo_in_t'{small_view[i], 1'(i == 9)});
    idx_valid <= 1'b0;
    wait_drained();

    // largest shapes and strides: some indexes overflow the offset, plus a dropped write
    cfg_words = '{32'h0000_FFFF, 32'h0000_FFFF, 32'h0000_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
    program_regs(cfg_words, 1'b1);
    send_index(spo_in_t'{32'hFFFF_FFFF, 1'b0});
    send_index(spo_in_t'{32'hFFFE_0001, 1'b1});
    send_index(spo_in_t'{32'hFFFE_0000, 1'b0});
    send_index(spo_in_t'{32'd65534, 1'b1});
    idx_valid <= 1'b0;
    wait_drained();

    // zero shapes act as one, so the outer digit takes the whole index
    cfg_words = '{32'hABCD_0000, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'd5, 32'd5, 32'd5};
    program_regs(cfg_words, 1'b0);
    send_index(spo_in_t'{32'hFFFF_FFFF, 1'b1});
    send_index(spo_in_t'{32'd12345, 1'b0});
    idx_valid <= 1'b0;
    wait_drained();

    // random phases, each with its own register setting
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p == 1) begin
        cfg_words = '{32'h0000_FFFF, 32'h0000_FFFF, 32'h0000_FFFF, 32'hFFFF_FFFF,
                      32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
      end else if (p == 2) begin
        cfg_words = '{32'd1, 32'd1, 32'd1, 32'd0, 32'd0, 32'd0, 32'd0};
      end else begin
        for (int i = 0; i < 3; i++) cfg_words[i] = random_shape_word();
        for (int i = 3; i < NUM_REGS; i++) cfg_words[i] = random_stride_word();
      end
      program_regs(cfg_words, ($urandom_range(0, 2) == 0));
      if (p == 3) begin
        // long receiver hold while indexes keep coming, so the input backs up
        hold_req = 1'b1;
        send_phase(250, 1'b0);
      end else begin
        count = 110;
        send_phase(count, (p % 2 == 0) || ($urandom_range(0, 1) == 1));
      end
      wait_drained();
    end

    // let any stray result surface before the verdict
    repeat (2 * PIPE_LATENCY) @(posedge clk);
    if (check_errors == 0 && pending_results == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
